[design/cpc_pkg.sv]
// Shared constants for the convex polygon plane cut block.
`default_nettype none
package cpc_pkg;
    localparam int DIST_W = 64;
    localparam int NORM_W = 18;
    localparam int LINE_W = 32;
    localparam int T_FRAC = 16;
    localparam int T_W = T_FRAC + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
    localparam logic [1:0] MAX_CUTS = 2'd2;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd5;
endpackage
`default_nettype wire

[design/cpc_queue.sv]
// Two-entry job queue between the vertex front end and the cut back end.
`default_nettype none
module cpc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

[design/cpc_front.sv]
// Front end: plane registers, vertex distance, side test and cut job issue.
`default_nettype none
module cpc_front #(
    parameter int CW = 32,
    parameter int IW = 32,
    parameter int CFGW = 32,
    parameter int JW = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFGW-1:0]               cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [CW-1:0]                 s_vertex_x,
    input  logic [CW-1:0]                 s_vertex_y,
    input  logic [CW-1:0]                 s_vertex_z,
    input  logic [IW-1:0]                 s_vertex_id,
    input  logic                          s_polygon_end,
    output logic                          job_push,
    output logic [JW-1:0]                 job_data,
    input  logic                          job_full
);
    import cpc_pkg::*;

    localparam int PW = CW + 1 + NORM_W;
    localparam int XW = (PW > DIST_W) ? PW : DIST_W;
    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_DIST  = 2'd1;
    localparam logic [1:0] F_EDGE  = 2'd2;
    localparam logic [1:0] F_CLOSE = 2'd3;

    logic [1:0] state_reg;
    logic signed [CW-1:0]     org_x_reg, org_y_reg, org_z_reg;
    logic signed [NORM_W-1:0] nrm_x_reg, nrm_y_reg, nrm_z_reg;

    logic [CW-1:0]     cur_x_reg, cur_y_reg, cur_z_reg;
    logic [IW-1:0]     cur_id_reg;
    logic              cur_last_reg;
    logic [DIST_W-1:0] px_reg, py_reg, pz_reg, d_reg;

    logic [CW-1:0]     first_x_reg, first_y_reg, first_z_reg, prev_x_reg, prev_y_reg, prev_z_reg;
    logic [IW-1:0]     first_id_reg, prev_id_reg;
    logic [DIST_W-1:0] first_d_reg, prev_d_reg;
    logic              start_reg;
    logic [1:0]        cuts_reg;
    logic [LINE_W-1:0] count_reg;

    logic signed [CW:0]     dx, dy, dz;
    logic signed [PW-1:0]   mx, my, mz;
    logic signed [XW-1:0]   ex, ey, ez;
    logic                   up_d, up_prev, up_first;
    logic                   edge_cut, close_cut;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == F_IDLE);

    assign dx = $signed({s_vertex_x[CW-1], s_vertex_x}) - $signed({org_x_reg[CW-1], org_x_reg});
    assign dy = $signed({s_vertex_y[CW-1], s_vertex_y}) - $signed({org_y_reg[CW-1], org_y_reg});
    assign dz = $signed({s_vertex_z[CW-1], s_vertex_z}) - $signed({org_z_reg[CW-1], org_z_reg});
    assign mx = dx * nrm_x_reg;
    assign my = dy * nrm_y_reg;
    assign mz = dz * nrm_z_reg;
    assign ex = mx;
    assign ey = my;
    assign ez = mz;

    assign up_d     = (d_reg != '0) && !d_reg[DIST_W-1];
    assign up_prev  = (prev_d_reg != '0) && !prev_d_reg[DIST_W-1];
    assign up_first = (first_d_reg != '0) && !first_d_reg[DIST_W-1];
    assign edge_cut  = !start_reg && (up_prev != up_d) && (cuts_reg < MAX_CUTS);
    assign close_cut = (up_d != up_first) && (cuts_reg < MAX_CUTS);

    always_comb begin
        job_push = 1'b0;
        job_data = {prev_x_reg, prev_y_reg, prev_z_reg, cur_x_reg, cur_y_reg, cur_z_reg,
                    prev_d_reg, d_reg, prev_id_reg, cur_id_reg, count_reg, cuts_reg[0]};
        if (state_reg == F_EDGE) begin
            job_push = edge_cut;
        end else if (state_reg == F_CLOSE) begin
            job_push = close_cut;
            job_data = {cur_x_reg, cur_y_reg, cur_z_reg, first_x_reg, first_y_reg, first_z_reg,
                        d_reg, first_d_reg, cur_id_reg, first_id_reg, count_reg, cuts_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cur_x_reg    <= s_vertex_x;
            cur_y_reg    <= s_vertex_y;
            cur_z_reg    <= s_vertex_z;
            cur_id_reg   <= s_vertex_id;
            cur_last_reg <= s_polygon_end;
            px_reg       <= ex[DIST_W-1:0];
            py_reg       <= ey[DIST_W-1:0];
            pz_reg       <= ez[DIST_W-1:0];
        end
        if (state_reg == F_DIST) begin
            d_reg <= px_reg + py_reg + pz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            org_x_reg   <= '0;
            org_y_reg   <= '0;
            org_z_reg   <= '0;
            nrm_x_reg   <= '0;
            nrm_y_reg   <= '0;
            nrm_z_reg   <= NORM_W'(65536);
            first_x_reg <= '0;
            first_y_reg <= '0;
            first_z_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prev_z_reg  <= '0;
            first_id_reg <= '0;
            prev_id_reg <= '0;
            first_d_reg <= '0;
            prev_d_reg  <= '0;
            start_reg   <= 1'b1;
            cuts_reg    <= 2'd0;
            count_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: org_x_reg <= cfg_data[CW-1:0];
                    CFG_ORIGIN_Y: org_y_reg <= cfg_data[CW-1:0];
                    CFG_ORIGIN_Z: org_z_reg <= cfg_data[CW-1:0];
                    CFG_NORMAL_X: nrm_x_reg <= cfg_data[NORM_W-1:0];
                    CFG_NORMAL_Y: nrm_y_reg <= cfg_data[NORM_W-1:0];
                    CFG_NORMAL_Z: nrm_z_reg <= cfg_data[NORM_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                F_IDLE: if (s_valid) state_reg <= F_DIST;
                F_DIST: state_reg <= F_EDGE;
                F_EDGE: begin
                    // hold until the queue takes the cut job
                    if (!(edge_cut && job_full)) begin
                        if (start_reg) begin
                            first_x_reg  <= cur_x_reg;
                            first_y_reg  <= cur_y_reg;
                            first_z_reg  <= cur_z_reg;
                            first_id_reg <= cur_id_reg;
                            first_d_reg  <= d_reg;
                            cuts_reg     <= 2'd0;
                            start_reg    <= 1'b0;
                        end else if (edge_cut) begin
                            cuts_reg <= cuts_reg + 2'd1;
                        end
                        prev_x_reg  <= cur_x_reg;
                        prev_y_reg  <= cur_y_reg;
                        prev_z_reg  <= cur_z_reg;
                        prev_id_reg <= cur_id_reg;
                        prev_d_reg  <= d_reg;
                        state_reg   <= cur_last_reg ? F_CLOSE : F_IDLE;
                    end
                end
                F_CLOSE: begin
                    if (!(close_cut && job_full)) begin
                        if (close_cut || cuts_reg != 2'd0) count_reg <= count_reg + LINE_W'(1);
                        cuts_reg  <= 2'd0;
                        start_reg <= 1'b1;
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/cpc_back.sv]
// Back end: cut parameter division and interpolation of the cut point.
`default_nettype none
module cpc_back #(
    parameter int CW = 32,
    parameter int IW = 32,
    parameter int JW = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_empty,
    input  logic [JW-1:0]     job_data,
    output logic              job_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CW-1:0]     m_cut_x,
    output logic [CW-1:0]     m_cut_y,
    output logic [CW-1:0]     m_cut_z,
    output logic [IW-1:0]     m_edge_start_id,
    output logic [IW-1:0]     m_edge_end_id,
    output logic [cpc_pkg::LINE_W-1:0] m_line_index,
    output logic              m_endpoint_index
);
    import cpc_pkg::*;

    localparam int MW = CW + 1 + T_W;
    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_DELTA = 4'd1;
    localparam logic [3:0] B_MAG   = 4'd2;
    localparam logic [3:0] B_SEL   = 4'd3;
    localparam logic [3:0] B_DIV   = 4'd4;
    localparam logic [3:0] B_DIFF  = 4'd5;
    localparam logic [3:0] B_ABS   = 4'd6;
    localparam logic [3:0] B_MUL   = 4'd7;
    localparam logic [3:0] B_ADD   = 4'd8;
    localparam logic [3:0] B_OUT   = 4'd9;

    logic [3:0]        state_reg;
    logic [CW-1:0]     p0_reg [3];
    logic [CW-1:0]     p1_reg [3];
    logic [CW-1:0]     res_reg [3];
    logic [DIST_W-1:0] d0_reg, d1_reg, delta_reg, a_reg, b_reg, r_reg;
    logic [T_W-1:0]    t_reg;
    logic [3:0]        iter_reg;
    logic [1:0]        c_reg;
    logic              skip_reg;
    logic signed [CW:0] diff_reg;
    logic [CW:0]       m_reg;
    logic [CW+1:0]     prod_reg;
    logic [IW-1:0]     id0_reg, id1_reg;
    logic [LINE_W-1:0] line_reg;
    logic              ep_reg;

    logic [DIST_W-1:0] r_shift;
    logic              r_carry, take;
    logic [MW-1:0]     mt;
    logic [CW+1:0]     x0_ext;

    assign job_pop = (state_reg == B_IDLE) && !job_empty;
    assign m_valid = (state_reg == B_OUT);
    assign m_cut_x = res_reg[0];
    assign m_cut_y = res_reg[1];
    assign m_cut_z = res_reg[2];
    assign m_edge_start_id  = id0_reg;
    assign m_edge_end_id    = id1_reg;
    assign m_line_index     = line_reg;
    assign m_endpoint_index = ep_reg;

    assign r_carry = r_reg[DIST_W-1];
    assign r_shift = {r_reg[DIST_W-2:0], 1'b0};
    assign take    = r_carry || (r_shift >= b_reg);
    assign mt      = MW'(m_reg) * MW'(t_reg);
    assign x0_ext  = {{2{p0_reg[c_reg][CW-1]}}, p0_reg[c_reg]};

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: if (!job_empty) begin
                {p0_reg[0], p0_reg[1], p0_reg[2], p1_reg[0], p1_reg[1], p1_reg[2],
                 d0_reg, d1_reg, id0_reg, id1_reg, line_reg, ep_reg} <= job_data;
            end
            B_DELTA: delta_reg <= d1_reg - d0_reg;
            B_MAG: begin
                a_reg    <= d0_reg[DIST_W-1] ? -d0_reg : d0_reg;
                b_reg    <= delta_reg[DIST_W-1] ? -delta_reg : delta_reg;
                skip_reg <= (delta_reg == '0) || (d0_reg == '0)
                            || (d0_reg[DIST_W-1] == delta_reg[DIST_W-1]);
            end
            B_SEL: begin
                r_reg    <= a_reg;
                iter_reg <= 4'd0;
                c_reg    <= 2'd0;
                if (skip_reg) t_reg <= '0;
                else if (a_reg >= b_reg) t_reg <= T_ONE;
                else t_reg <= '0;
            end
            B_DIV: begin
                r_reg    <= take ? r_shift - b_reg : r_shift;
                t_reg    <= {t_reg[T_W-2:0], take};
                iter_reg <= iter_reg + 4'd1;
            end
            B_DIFF: diff_reg <= $signed({p1_reg[c_reg][CW-1], p1_reg[c_reg]})
                                - $signed({p0_reg[c_reg][CW-1], p0_reg[c_reg]});
            B_ABS: m_reg <= diff_reg[CW] ? CW'(0) - diff_reg : diff_reg;
            B_MUL: prod_reg <= mt[MW-1:T_FRAC];
            B_ADD: begin
                res_reg[c_reg] <= diff_reg[CW] ? CW'(x0_ext - prod_reg) : CW'(x0_ext + prod_reg);
                c_reg <= c_reg + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            unique case (state_reg)
                B_IDLE:  if (!job_empty) state_reg <= B_DELTA;
                B_DELTA: state_reg <= B_MAG;
                B_MAG:   state_reg <= B_SEL;
                B_SEL:   state_reg <= (skip_reg || a_reg >= b_reg) ? B_DIFF : B_DIV;
                B_DIV:   if (iter_reg == 4'(T_FRAC - 1)) state_reg <= B_DIFF;
                B_DIFF:  state_reg <= B_ABS;
                B_ABS:   state_reg <= B_MUL;
                B_MUL:   state_reg <= B_ADD;
                B_ADD:   state_reg <= (c_reg == 2'd2) ? B_OUT : B_DIFF;
                B_OUT:   if (m_ready) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/convex_polygon_plane_cut.sv]
// Top level of the convex polygon plane cut block.
// Vertices of convex polygons stream in on s_, one item per vertex, polygon_end on the
// last one; every cut edge (at most two per polygon) yields one item on m_ with the
// interpolated point, edge ids, line index and endpoint number. The front end takes a
// vertex in F_IDLE and steps it through F_DIST and F_EDGE, and through F_CLOSE on a
// polygon's last vertex for the closing edge; issuing a cut job stalls it only while the
// job queue is full. The back end works on one cut at a time: it loads and sets up the
// job, finds t with a radix-2 divider, works each coordinate in turn on one multiplier
// and presents the result until m_ready; the divider is skipped when t is 0 or 1.
// Throughput is set by the back end when polygons are cut and by the front end otherwise.
// A two-entry job queue lets both halves stall independently.
`default_nettype none
module convex_polygon_plane_cut #(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((COORD_WIDTH > 18) ? COORD_WIDTH : 18)-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [COORD_WIDTH-1:0]        s_vertex_x,
    input  logic [COORD_WIDTH-1:0]        s_vertex_y,
    input  logic [COORD_WIDTH-1:0]        s_vertex_z,
    input  logic [ID_WIDTH-1:0]           s_vertex_id,
    input  logic                          s_polygon_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_WIDTH-1:0]        m_cut_x,
    output logic [COORD_WIDTH-1:0]        m_cut_y,
    output logic [COORD_WIDTH-1:0]        m_cut_z,
    output logic [ID_WIDTH-1:0]           m_edge_start_id,
    output logic [ID_WIDTH-1:0]           m_edge_end_id,
    output logic [cpc_pkg::LINE_W-1:0]    m_line_index,
    output logic                          m_endpoint_index
);
    import cpc_pkg::*;

    localparam int CFGW = (COORD_WIDTH > 18) ? COORD_WIDTH : 18;
    localparam int JW = 6 * COORD_WIDTH + 2 * DIST_W + 2 * ID_WIDTH + LINE_W + 1;

    logic          q_push, q_full, q_pop, q_empty;
    logic [JW-1:0] q_in, q_out;

    cpc_front #(.CW(COORD_WIDTH), .IW(ID_WIDTH), .CFGW(CFGW), .JW(JW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_vertex_x(s_vertex_x),
        .s_vertex_y(s_vertex_y), .s_vertex_z(s_vertex_z), .s_vertex_id(s_vertex_id),
        .s_polygon_end(s_polygon_end),
        .job_push(q_push), .job_data(q_in), .job_full(q_full)
    );

    cpc_queue #(.WIDTH(JW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .empty(q_empty)
    );

    cpc_back #(.CW(COORD_WIDTH), .IW(ID_WIDTH), .JW(JW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_empty(q_empty), .job_data(q_out), .job_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cut_x(m_cut_x), .m_cut_y(m_cut_y), .m_cut_z(m_cut_z),
        .m_edge_start_id(m_edge_start_id), .m_edge_end_id(m_edge_end_id),
        .m_line_index(m_line_index), .m_endpoint_index(m_endpoint_index)
    );
endmodule
`default_nettype wire
